// ===== sv/brb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer with block reader.
// ----------------------------------------------------------------------------
package brb_pkg;

	// Storage size in bytes; must be a power of two (128 .. 1048576)
	localparam int DEPTH       = 4096;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int LVL_W       = $clog2(DEPTH + 1);
	localparam int CNT_W       = 13;
	localparam int RSV_W       = 7;
	localparam int IDX_W       = 12;
	localparam int SKIP_W      = 32;
	localparam int TOT_W       = 64;
	localparam int OUT_LVL_W   = 13;
	localparam int CMP_W       = ((LVL_W > CNT_W) ? LVL_W : CNT_W) + 1;
	localparam int PEEK_LIMIT  = 64;
	localparam int PEEK_W      = 7;
	localparam int RESERVE_RST = 16;
	localparam int SAT_LVL     = 8191;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 88;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [LVL_W-1:0]     lvl_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [RSV_W-1:0]     rsv_t;
	typedef logic [TOT_W-1:0]     tot_t;
	typedef logic [CMP_W-1:0]     cmp_t;
	typedef logic [OUT_LVL_W-1:0] olvl_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [SKIP_W-1:0]    skip_t;
	typedef logic [PEEK_W-1:0]    peek_t;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_QUERY = 3'd3,
		OP_CLAIM = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_BAD_LEN    = 3'd1,
		STAT_NO_ROOM    = 3'd2,
		STAT_NOT_ENOUGH = 3'd3,
		STAT_TOO_LARGE  = 3'd4,
		STAT_NOT_READY  = 3'd5,
		STAT_BAD_BLOCK  = 3'd6
	} status_t;

	// Classified request handed from front to back
	typedef struct packed {
		op_t         op;
		logic [7:0]  data_byte;
		cnt_t        count;
		logic        last;
		status_t     pre_err;   // error known from the request alone
		logic        blk_big;   // block size above half the storage
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  read_byte;
		logic        final_res;
		olvl_t       fill_level;
		olvl_t       free_space;
		idx_t        block_index;
		skip_t       skipped;
	} res_t;

endpackage

// ===== sv/byte_ring_buffer_with_block_reader_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_block_reader_top
// Byte ring buffer with push bursts, pop, peek, level query and block claim.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser opcode; tdata byte, count; tlast
//  m_*       out  m_tvalid/m_tready  tdata status..skipped; tlast final
//  reserve   in   reserve_we         reserve_wdata (7 bits)
//
//  Push, pop, query and errors complete in the executor from the idle state.
//  Peek of N bytes: a registered RAM read per byte, then that byte's output.
//  Block claim steps through cursor subtract, skip and status.
//  Reset: asynchronous; totals and cursors clear, reserve returns to 16;
//  storage is not cleared and no clearing pass runs.
//  A stalled m_tready holds the result register; the 2-entry queue keeps
//  taking requests until full.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_block_reader_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [7:0] data_byte, [20:8] count, [23:21] zero
	input  logic [brb_pkg::IN_TDATA_W-1:0]       s_tdata,
	// [2:0] opcode
	input  logic [2:0]                           s_tuser,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [2:0] status, [10:3] read_byte, [23:11] fill_level, [36:24] free_space,
	// [48:37] block_index, [80:49] skipped, [87:81] zero
	output logic [brb_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                 m_tlast,
	input  logic                                 reserve_we,
	input  logic [brb_pkg::RSV_W-1:0]            reserve_wdata
);

	brb_pkg::rsv_t reserve_q;
	brb_pkg::lvl_t cap_q;
	logic          fq_valid;
	logic          fq_ready;
	brb_pkg::cmd_t fq_cmd;
	logic          qb_valid;
	logic          qb_ready;
	brb_pkg::cmd_t qb_cmd;
	brb_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserve_q <= brb_pkg::rsv_t'(brb_pkg::RESERVE_RST);
			cap_q     <= brb_pkg::lvl_t'(brb_pkg::DEPTH - brb_pkg::RESERVE_RST);
		end else if (reserve_we) begin
			reserve_q <= reserve_wdata;
			cap_q     <= brb_pkg::lvl_t'(brb_pkg::DEPTH) - brb_pkg::lvl_t'(reserve_wdata);
		end
	end

	brb_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.reserve  (reserve_q),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_cmd    (fq_cmd)
	);

	brb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_cmd   (qb_cmd)
	);

	brb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.cap       (cap_q),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_res     (res)
	);

	assign m_tdata = {7'b0, res.skipped, res.block_index, res.free_space,
		res.fill_level, res.read_byte, res.status};
	assign m_tlast = res.final_res;

endmodule

// ===== sv/brb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/brb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_front
// Accepts requests, drops unknown opcodes and flags length, peek size and block errors.
// ----------------------------------------------------------------------------
module brb_front (
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [brb_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic [2:0]                          s_tuser,
	input  logic                                s_tlast,
	input  brb_pkg::rsv_t                       reserve,
	output logic                                q_valid,
	input  logic                                q_ready,
	output brb_pkg::cmd_t                       q_cmd
);

	brb_pkg::cnt_t cnt;
	brb_pkg::op_t  op;
	logic          known;
	logic          cnt_zero;
	logic          pow2;
	logic          blk_ok;
	logic          peek_big;

	assign op       = brb_pkg::op_t'(s_tuser);
	assign cnt      = s_tdata[20:8];
	assign known    = s_tuser <= brb_pkg::OP_CLAIM;
	assign cnt_zero = cnt == '0;
	assign pow2     = (cnt & (cnt - brb_pkg::cnt_t'(1))) == '0;
	assign blk_ok   = !cnt_zero && pow2 && (32'(cnt) <= 32'(brb_pkg::DEPTH));
	assign peek_big = (cnt > brb_pkg::cnt_t'(reserve))
		|| (cnt > brb_pkg::cnt_t'(brb_pkg::PEEK_LIMIT));

	// unknown opcodes are taken and dropped
	assign s_tready = q_ready;
	assign q_valid  = s_tvalid && known;

	always_comb begin
		q_cmd.op        = op;
		q_cmd.data_byte = s_tdata[7:0];
		q_cmd.count     = cnt;
		q_cmd.last      = s_tlast;
		q_cmd.blk_big   = 32'(cnt) > 32'(brb_pkg::DEPTH / 2);
		q_cmd.pre_err   = brb_pkg::STAT_OK;
		unique case (op)
			brb_pkg::OP_PUSH, brb_pkg::OP_POP: begin
				if (cnt_zero) q_cmd.pre_err = brb_pkg::STAT_BAD_LEN;
			end
			brb_pkg::OP_PEEK: begin
				if (cnt_zero) q_cmd.pre_err = brb_pkg::STAT_BAD_LEN;
				else if (peek_big) q_cmd.pre_err = brb_pkg::STAT_TOO_LARGE;
			end
			brb_pkg::OP_CLAIM: begin
				if (!blk_ok) q_cmd.pre_err = brb_pkg::STAT_BAD_BLOCK;
			end
			default: begin
				q_cmd.pre_err = brb_pkg::STAT_OK;
			end
		endcase
	end

endmodule

// ===== sv/brb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module brb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  brb_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output brb_pkg::cmd_t out_cmd
);

	brb_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    level_q;
	logic          push;
	logic          pop;

	assign in_ready  = level_q != 2'd2;
	assign out_valid = level_q != 2'd0;
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			level_q <= level_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

// ===== sv/brb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_back
// Executes requests against the byte store and drives the result register.
// ----------------------------------------------------------------------------
module brb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  brb_pkg::cmd_t cmd,
	input  brb_pkg::lvl_t cap,
	output logic          m_valid,
	input  logic          m_ready,
	output brb_pkg::res_t m_res
);

	typedef enum logic [4:0] {
		S_IDLE       = 5'b00001,
		S_PEEK_RD    = 5'b00010,
		S_PEEK_OUT   = 5'b00100,
		S_CLAIM_SKIP = 5'b01000,
		S_CLAIM_OUT  = 5'b10000
	} state_t;

	function automatic brb_pkg::olvl_t sat_lvl(input brb_pkg::lvl_t v);
		return (32'(v) > 32'(brb_pkg::SAT_LVL)) ? brb_pkg::olvl_t'(brb_pkg::SAT_LVL)
			: brb_pkg::olvl_t'(v);
	endfunction

	state_t         state_q, state_d;
	brb_pkg::tot_t  wt_q, wt_d;
	brb_pkg::tot_t  bc_q, bc_d;
	brb_pkg::tot_t  span_q, span_d;
	brb_pkg::addr_t rd_ptr_q, rd_ptr_d;
	brb_pkg::lvl_t  fill_q, fill_d;
	logic           in_burst_q, in_burst_d;
	logic           burst_ok_q, burst_ok_d;
	brb_pkg::addr_t peek_addr_q, peek_addr_d;
	brb_pkg::peek_t peek_left_q, peek_left_d;
	brb_pkg::cnt_t  blk_cnt_q, blk_cnt_d;
	logic           blk_big_q, blk_big_d;
	brb_pkg::lvl_t  avail_q, avail_d;
	brb_pkg::skip_t skip_q, skip_d;
	logic           out_valid_q;
	brb_pkg::res_t  out_res_q;

	logic           out_free;
	logic           res_load;
	brb_pkg::res_t  res_d;
	logic           ram_we;
	logic           ram_re;
	logic [7:0]     ram_rdata;

	logic           room_ok;
	logic           push_ok;
	logic           has_space;
	logic           short_data;
	brb_pkg::lvl_t  free_lvl;
	logic           over;
	brb_pkg::tot_t  excess;
	logic           blk_short;

	assign out_free   = !out_valid_q || m_ready;
	assign room_ok    = (brb_pkg::cmp_t'(fill_q) + brb_pkg::cmp_t'(cmd.count))
		<= brb_pkg::cmp_t'(cap);
	assign push_ok    = in_burst_q ? burst_ok_q
		: (cmd.pre_err == brb_pkg::STAT_OK) && room_ok;
	assign has_space  = fill_q < cap;
	assign short_data = brb_pkg::cmp_t'(cmd.count) > brb_pkg::cmp_t'(fill_q);
	assign free_lvl   = (cap > fill_q) ? cap - fill_q : '0;
	assign over       = span_q > brb_pkg::tot_t'(cap);
	assign excess     = span_q - brb_pkg::tot_t'(cap);
	assign blk_short  = brb_pkg::cmp_t'(blk_cnt_q) > brb_pkg::cmp_t'(avail_q);

	brb_ram #(
		.WIDTH (8),
		.DEPTH (brb_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wt_q[brb_pkg::ADDR_W-1:0]),
		.wdata (cmd.data_byte),
		.re    (ram_re),
		.raddr (peek_addr_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d     = state_q;
		wt_d        = wt_q;
		bc_d        = bc_q;
		span_d      = span_q;
		rd_ptr_d    = rd_ptr_q;
		fill_d      = fill_q;
		in_burst_d  = in_burst_q;
		burst_ok_d  = burst_ok_q;
		peek_addr_d = peek_addr_q;
		peek_left_d = peek_left_q;
		blk_cnt_d   = blk_cnt_q;
		blk_big_d   = blk_big_q;
		avail_d     = avail_q;
		skip_d      = skip_q;
		cmd_ready   = 1'b0;
		res_load    = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		res_d           = '0;
		res_d.final_res = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						brb_pkg::OP_PUSH: begin
							if (out_free) begin
								cmd_ready  = 1'b1;
								res_load   = 1'b1;
								in_burst_d = !cmd.last;
								burst_ok_d = push_ok;
								if (push_ok && has_space) begin
									ram_we       = 1'b1;
									wt_d         = wt_q + brb_pkg::tot_t'(1);
									fill_d       = fill_q + brb_pkg::lvl_t'(1);
									res_d.status = brb_pkg::STAT_OK;
								end else if (!push_ok && !in_burst_q
									&& cmd.pre_err != brb_pkg::STAT_OK) begin
									res_d.status = cmd.pre_err;
								end else begin
									res_d.status = brb_pkg::STAT_NO_ROOM;
								end
							end
						end
						brb_pkg::OP_POP: begin
							if (out_free) begin
								cmd_ready  = 1'b1;
								res_load   = 1'b1;
								in_burst_d = 1'b0;
								if (cmd.pre_err != brb_pkg::STAT_OK) begin
									res_d.status = cmd.pre_err;
								end else if (short_data) begin
									res_d.status = brb_pkg::STAT_NOT_ENOUGH;
								end else begin
									rd_ptr_d = rd_ptr_q + brb_pkg::addr_t'(cmd.count);
									fill_d   = fill_q - brb_pkg::lvl_t'(cmd.count);
								end
							end
						end
						brb_pkg::OP_PEEK: begin
							if (cmd.pre_err == brb_pkg::STAT_OK && !short_data) begin
								// launch the byte walk; no result yet
								cmd_ready   = 1'b1;
								in_burst_d  = 1'b0;
								peek_addr_d = rd_ptr_q;
								peek_left_d = brb_pkg::peek_t'(cmd.count);
								state_d     = S_PEEK_RD;
							end else if (out_free) begin
								cmd_ready    = 1'b1;
								res_load     = 1'b1;
								in_burst_d   = 1'b0;
								res_d.status = (cmd.pre_err != brb_pkg::STAT_OK)
									? cmd.pre_err : brb_pkg::STAT_NOT_ENOUGH;
							end
						end
						brb_pkg::OP_QUERY: begin
							if (out_free) begin
								cmd_ready        = 1'b1;
								res_load         = 1'b1;
								in_burst_d       = 1'b0;
								res_d.fill_level = sat_lvl(fill_q);
								res_d.free_space = sat_lvl(free_lvl);
							end
						end
						brb_pkg::OP_CLAIM: begin
							if (cmd.pre_err == brb_pkg::STAT_OK) begin
								cmd_ready  = 1'b1;
								in_burst_d = 1'b0;
								span_d     = wt_q - bc_q;
								blk_cnt_d  = cmd.count;
								blk_big_d  = cmd.blk_big;
								state_d    = S_CLAIM_SKIP;
							end else if (out_free) begin
								cmd_ready    = 1'b1;
								res_load     = 1'b1;
								in_burst_d   = 1'b0;
								res_d.status = cmd.pre_err;
							end
						end
						default: begin
							cmd_ready = 1'b1;
						end
					endcase
				end
			end
			S_PEEK_RD: begin
				ram_re  = 1'b1;
				state_d = S_PEEK_OUT;
			end
			S_PEEK_OUT: begin
				if (out_free) begin
					res_load        = 1'b1;
					res_d.read_byte = ram_rdata;
					res_d.final_res = peek_left_q == brb_pkg::peek_t'(1);
					peek_addr_d     = peek_addr_q + brb_pkg::addr_t'(1);
					peek_left_d     = peek_left_q - brb_pkg::peek_t'(1);
					state_d         = (peek_left_q == brb_pkg::peek_t'(1)) ? S_IDLE
						: S_PEEK_RD;
				end
			end
			S_CLAIM_SKIP: begin
				// jump the cursor past overwritten bytes
				if (over) begin
					skip_d  = (|excess[brb_pkg::TOT_W-1:brb_pkg::SKIP_W]) ? '1
						: excess[brb_pkg::SKIP_W-1:0];
					bc_d    = wt_q - brb_pkg::tot_t'(cap);
					avail_d = cap;
				end else begin
					skip_d  = '0;
					avail_d = brb_pkg::lvl_t'(span_q);
				end
				state_d = S_CLAIM_OUT;
			end
			S_CLAIM_OUT: begin
				if (out_free) begin
					res_load      = 1'b1;
					res_d.skipped = skip_q;
					if (blk_big_q) begin
						res_d.status = brb_pkg::STAT_BAD_BLOCK;
					end else if (blk_short) begin
						res_d.status = brb_pkg::STAT_NOT_READY;
					end else begin
						res_d.block_index = brb_pkg::idx_t'(bc_q[brb_pkg::ADDR_W-1:0]);
						bc_d              = bc_q + brb_pkg::tot_t'(blk_cnt_q);
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wt_q        <= '0;
			bc_q        <= '0;
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			in_burst_q  <= 1'b0;
			burst_ok_q  <= 1'b0;
			peek_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			wt_q        <= wt_d;
			bc_q        <= bc_d;
			rd_ptr_q    <= rd_ptr_d;
			fill_q      <= fill_d;
			in_burst_q  <= in_burst_d;
			burst_ok_q  <= burst_ok_d;
			peek_left_q <= peek_left_d;
			if (res_load) out_valid_q <= 1'b1;
			else if (m_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		span_q      <= span_d;
		peek_addr_q <= peek_addr_d;
		blk_cnt_q   <= blk_cnt_d;
		blk_big_q   <= blk_big_d;
		avail_q     <= avail_d;
		skip_q      <= skip_d;
		if (res_load) out_res_q <= res_d;
	end

	assign m_valid = out_valid_q;
	assign m_res   = out_res_q;

endmodule

// ===== sv/brb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks on the result stream of the ring buffer.
// ----------------------------------------------------------------------------
module brb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [brb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tlast
);

	logic [13:0] lvl_sum;

	assign lvl_sum = {1'b0, m_tdata[23:11]} + {1'b0, m_tdata[36:24]};

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= brb_pkg::STAT_BAD_BLOCK)
		else $error("status code out of range");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != brb_pkg::STAT_OK |-> m_tlast)
		else $error("error result not final");

	a_level_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(lvl_sum) <= 32'(brb_pkg::DEPTH))
		else $error("fill plus free exceeds storage");

endmodule

bind byte_ring_buffer_with_block_reader_top brb_checker u_brb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte ring buffer with block reader. Requests are
// queued by a stimulus process, driven by a clocked driver and mirrored into a
// behavioral ring model that predicts every response. A clocked monitor
// compares each response, field by field, with the oldest prediction. Both
// handshakes idle at random, and the reserve register is changed between
// phases while the buffer is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import brb_pkg::*;

	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 160;
	localparam int IDLE_LIMIT    = 4000;
	localparam int MIX_ITEMS     = 45;
	localparam int REQ_SLOTS     = 1024;
	localparam int RSP_SLOTS     = 1024;

	typedef struct {
		logic [2:0] op;
		logic [7:0] data_byte;
		cnt_t       count;
		logic       last;
	} request_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_tvalid      = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata       = '0;
	logic [2:0]             s_tuser       = '0;
	logic                   s_tlast       = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready      = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   reserve_we    = 1'b0;
	rsv_t                   reserve_wdata = '0;

	// pending requests and awaited responses, kept as rings with head and tail
	request_t req_store [REQ_SLOTS];
	int       req_head = 0;
	int       req_tail = 0;
	res_t     rsp_store [RSP_SLOTS];
	int       rsp_head = 0;
	int       rsp_tail = 0;

	// ring model state
	logic [7:0] ring_mem [DEPTH];
	tot_t       wr_total    = '0;
	tot_t       rd_total    = '0;
	tot_t       blk_cursor  = '0;
	logic       in_burst    = 1'b0;
	logic       burst_ok    = 1'b0;
	rsv_t       reserve_val = rsv_t'(RESERVE_RST);

	int   mismatch_count = 0;
	int   send_gap       = 0;
	int   ready_gap      = 0;
	int   idle_cycles    = 0;
	int   holds_wanted   = 0;
	int   holds_done     = 0;

	byte_ring_buffer_with_block_reader_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.reserve_we    (reserve_we),
		.reserve_wdata (reserve_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void record_response(res_t res);
		rsp_store[rsp_tail % RSP_SLOTS] = res;
		rsp_tail++;
	endfunction

	// Update the ring model with one accepted request and queue its responses.
	function automatic void apply_request(logic [2:0] op, logic [7:0] data_byte,
	                                      cnt_t count, logic last);
		tot_t    cap;
		tot_t    fill;
		tot_t    span;
		tot_t    skip;
		tot_t    room;
		status_t st;
		res_t    res;
		int      k;
		cap = (reserve_val >= DEPTH) ? '0 : tot_t'(DEPTH) - tot_t'(reserve_val);
		fill = wr_total - rd_total;
		res = '0;
		res.final_res = 1'b1;
		st = STAT_OK;
		if (op > OP_CLAIM)
			return;
		if (op == OP_PUSH) begin
			if (!in_burst) begin
				if (count == 0) begin
					st = STAT_BAD_LEN;
					burst_ok = 1'b0;
				end else if (fill + count > cap) begin
					st = STAT_NO_ROOM;
					burst_ok = 1'b0;
				end else begin
					burst_ok = 1'b1;
				end
			end else begin
				st = burst_ok ? STAT_OK : STAT_NO_ROOM;
			end
			if (burst_ok) begin
				if (fill < cap) begin
					ring_mem[addr_t'(wr_total)] = data_byte;
					wr_total = wr_total + 1;
					st = STAT_OK;
				end else begin
					st = STAT_NO_ROOM;
				end
			end
			in_burst = !last;
		end else begin
			in_burst = 1'b0;
			case (op)
			OP_POP: begin
				if (count == 0)
					st = STAT_BAD_LEN;
				else if (count > fill)
					st = STAT_NOT_ENOUGH;
				else
					rd_total = rd_total + count;
			end
			OP_PEEK: begin
				if (count == 0)
					st = STAT_BAD_LEN;
				else if (count > reserve_val || count > PEEK_LIMIT)
					st = STAT_TOO_LARGE;
				else if (count > fill)
					st = STAT_NOT_ENOUGH;
				if (st == STAT_OK) begin
					for (k = 0; k < int'(count); k++) begin
						res.read_byte = ring_mem[addr_t'(rd_total + tot_t'(k))];
						res.final_res = (k + 1 == int'(count));
						record_response(res);
					end
					return;
				end
			end
			OP_QUERY: begin
				room = (cap > fill) ? cap - fill : '0;
				res.fill_level = (fill > SAT_LVL) ? olvl_t'(SAT_LVL) : olvl_t'(fill);
				res.free_space = (room > SAT_LVL) ? olvl_t'(SAT_LVL) : olvl_t'(room);
			end
			default: begin
				if (count == 0 || (DEPTH % int'(count)) != 0) begin
					st = STAT_BAD_BLOCK;
				end else begin
					// jump the reader past data that writers have overrun
					span = wr_total - blk_cursor;
					skip = '0;
					if (span > cap) begin
						skip = span - cap;
						blk_cursor = wr_total - cap;
					end
					res.skipped = (skip > 64'hFFFF_FFFF) ? '1 : skip[31:0];
					if (count > DEPTH / 2) begin
						st = STAT_BAD_BLOCK;
					end else if (blk_cursor + count > wr_total) begin
						st = STAT_NOT_READY;
					end else begin
						res.block_index = idx_t'(blk_cursor);
						blk_cursor = blk_cursor + count;
					end
				end
			end
			endcase
		end
		res.status = st;
		record_response(res);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		request_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (req_head != req_tail) begin
				req = req_store[req_head % REQ_SLOTS];
				req_head++;
				s_tuser  <= req.op;
				s_tdata  <= {3'b000, req.count, req.data_byte};
				s_tlast  <= req.last;
				s_tvalid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// response ready, with random gaps and an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			ready_gap <= 0;
		end else if (holds_done != holds_wanted) begin
			m_tready   <= 1'b0;
			ready_gap  <= LONG_HOLD;
			holds_done <= holds_done + 1;
		end else if (ready_gap > 0) begin
			m_tready  <= 1'b0;
			ready_gap <= ready_gap - 1;
		end else begin
			m_tready  <= 1'b1;
			ready_gap <= pick_gap();
		end
	end

	// predict on every accepted request
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			apply_request(s_tuser, s_tdata[7:0], s_tdata[20:8], s_tlast);
	end

	// compare every accepted response
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (rsp_head == rsp_tail) begin
				$display("%0t: unexpected response, expected none, actual tdata %h tlast %b",
				         $time, m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				want = rsp_store[rsp_head % RSP_SLOTS];
				rsp_head++;
				check_field("status", want.status, m_tdata[2:0]);
				check_field("read_byte", want.read_byte, m_tdata[10:3]);
				check_field("fill_level", want.fill_level, m_tdata[23:11]);
				check_field("free_space", want.free_space, m_tdata[36:24]);
				check_field("block_index", want.block_index, m_tdata[48:37]);
				check_field("skipped", want.skipped, m_tdata[80:49]);
				check_field("final_res", want.final_res, m_tlast);
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_request(logic [2:0] op, logic [7:0] data_byte, cnt_t count,
	                             logic last);
		req_store[req_tail % REQ_SLOTS] = request_t'{op, data_byte, count, last};
		req_tail++;
	endtask

	// push burst: the first byte carries the length, later counts are ignored
	task automatic queue_burst(int len, cnt_t count);
		int i;
		for (i = 0; i < len; i++)
			queue_request(OP_PUSH, 8'($urandom), (i == 0) ? count : cnt_t'($urandom),
			              i == len - 1);
	endtask

	// hold further requests until every response is back, then let the block settle
	task automatic drain_and_wait();
		do
			@(negedge clk);
		while (req_head != req_tail || s_tvalid || rsp_head != rsp_tail);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reserve(rsv_t value);
		@(posedge clk);
		reserve_we    <= 1'b1;
		reserve_wdata <= value;
		reserve_val = value;
		@(posedge clk);
		reserve_we <= 1'b0;
		@(negedge clk);
	endtask

	// mostly well-formed traffic with random content, some raw noise
	task automatic queue_random_mix(int target);
		int   added;
		int   r;
		int   len;
		int   fill_est;
		int   lim;
		cnt_t cnt;
		logic [2:0] op;
		added = 0;
		fill_est = int'(wr_total - rd_total);
		while (added < target) begin
			r = $urandom_range(0, 99);
			if (fill_est > 600 && r < 40)
				r = 40;
			if (r < 35) begin
				len = $urandom_range(1, 24);
				case ($urandom_range(0, 9))
				0: cnt = cnt_t'($urandom_range(0, 8191));
				1: cnt = cnt_t'(len + $urandom_range(1, 6));
				2: cnt = cnt_t'($urandom_range(1, len));
				default: cnt = cnt_t'(len);
				endcase
				queue_burst(len, cnt);
				if (cnt != 0 && cnt < 3000)
					fill_est += len;
				added += len;
			end else if (r < 55) begin
				if (fill_est > 0 && $urandom_range(0, 4) != 0)
					cnt = cnt_t'($urandom_range(1, (fill_est > 200) ? 200 : fill_est));
				else
					cnt = cnt_t'($urandom_range(0, 100));
				queue_request(OP_POP, 8'($urandom), cnt, 1'($urandom));
				if (cnt <= fill_est)
					fill_est -= cnt;
				added++;
			end else if (r < 70) begin
				lim = (reserve_val < PEEK_LIMIT) ? int'(reserve_val) : PEEK_LIMIT;
				if (fill_est < lim)
					lim = fill_est;
				if (lim > 0 && $urandom_range(0, 6) != 0)
					cnt = cnt_t'($urandom_range(1, lim));
				else
					cnt = cnt_t'($urandom_range(0, 80));
				queue_request(OP_PEEK, 8'($urandom), cnt, 1'($urandom));
				added++;
			end else if (r < 78) begin
				queue_request(OP_QUERY, 8'($urandom), cnt_t'($urandom), 1'($urandom));
				added++;
			end else if (r < 88) begin
				case ($urandom_range(0, 9))
				0: cnt = cnt_t'(1 << $urandom_range(7, 12));
				1: cnt = cnt_t'($urandom_range(0, 8191));
				default: cnt = cnt_t'(1 << $urandom_range(0, 6));
				endcase
				queue_request(OP_CLAIM, 8'($urandom), cnt, 1'($urandom));
				added++;
			end else begin
				op = 3'($urandom_range(0, 7));
				queue_request(op, 8'($urandom), cnt_t'($urandom_range(0, 8191)),
				              1'($urandom));
				if (op <= OP_CLAIM)
					added++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: errors on an empty buffer, then small bursts
		queue_request(OP_QUERY, 8'h00, 13'd0, 1'b1);
		queue_request(OP_POP, 8'h00, 13'd0, 1'b1);
		queue_request(OP_POP, 8'h00, 13'd1, 1'b1);
		queue_request(OP_PEEK, 8'h00, 13'd0, 1'b1);
		queue_request(OP_PEEK, 8'h00, 13'd17, 1'b1);
		queue_request(OP_PEEK, 8'h00, 13'd4, 1'b1);
		queue_request(OP_CLAIM, 8'h00, 13'd0, 1'b1);
		queue_request(OP_CLAIM, 8'h00, 13'd3, 1'b1);
		queue_request(OP_CLAIM, 8'h00, 13'd8, 1'b1);
		queue_request(OP_PUSH, 8'hFF, 13'd0, 1'b1);
		// refused burst: every byte reports no room
		queue_burst(3, 13'h1FFF);
		queue_request(OP_PUSH, 8'h00, 13'd5, 1'b0);
		queue_request(OP_PUSH, 8'hFF, 13'd0, 1'b0);
		queue_request(OP_PUSH, 8'hA5, 13'd0, 1'b0);
		queue_request(OP_PUSH, 8'h5A, 13'd0, 1'b0);
		queue_request(OP_PUSH, 8'h3C, 13'd0, 1'b1);
		queue_request(OP_PEEK, 8'h00, 13'd5, 1'b1);
		queue_request(OP_POP, 8'h00, 13'd2, 1'b1);
		// burst longer than its count
		queue_burst(4, 13'd2);
		// open burst ended by another operation
		queue_request(OP_PUSH, 8'h81, 13'd3, 1'b0);
		queue_request(OP_PUSH, 8'h7E, 13'd0, 1'b0);
		queue_request(OP_QUERY, 8'h00, 13'd0, 1'b0);
		queue_request(3'd5, 8'h00, 13'd1, 1'b1);
		queue_request(3'd6, 8'h00, 13'd1, 1'b1);
		queue_request(3'd7, 8'h00, 13'd1, 1'b1);
		queue_request(OP_CLAIM, 8'h00, 13'd4, 1'b1);
		queue_request(OP_CLAIM, 8'h00, 13'd4096, 1'b1);
		drain_and_wait();

		// largest reserve: longest peek, oversize peek, claims on fresh data
		set_reserve(rsv_t'(127));
		queue_burst(64, 13'd64);
		queue_request(OP_QUERY, 8'h00, 13'd0, 1'b1);
		queue_request(OP_PEEK, 8'h00, 13'd64, 1'b1);
		queue_request(OP_PEEK, 8'h00, 13'd65, 1'b1);
		queue_request(OP_CLAIM, 8'h00, 13'd64, 1'b1);
		queue_request(OP_CLAIM, 8'h00, 13'd2048, 1'b1);
		drain_and_wait();

		// hold the response side off while requests keep coming
		holds_wanted = holds_wanted + 1;
		repeat (3) queue_request(OP_PEEK, 8'h00, 13'd64, 1'b1);
		queue_burst(20, 13'd20);
		queue_request(OP_QUERY, 8'h00, 13'd0, 1'b1);
		queue_request(OP_CLAIM, 8'h00, 13'd16, 1'b1);
		queue_request(OP_POP, 8'h00, 13'd30, 1'b1);
		drain_and_wait();

		set_reserve(rsv_t'(64));
		queue_random_mix(MIX_ITEMS);
		drain_and_wait();
		set_reserve(rsv_t'($urandom_range(1, 127)));
		queue_random_mix(MIX_ITEMS);
		drain_and_wait();
		set_reserve(rsv_t'(RESERVE_RST));
		queue_random_mix(MIX_ITEMS);
		drain_and_wait();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
